// ----- hdl/pcbhm_pkg.sv -----
// ----------------------------------------------------------------------------
// PHY control-register bus master package
// Shared types and constants for the handshake master and its submodules.
// ----------------------------------------------------------------------------
package pcbhm_pkg;

   localparam int TIMEOUT_W = 32;
   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 32'd1000000;

   // Handshake phases. Each strobe phase waits for ack high, each release
   // phase waits for ack low.
   typedef enum logic [3:0] {
      PH_IDLE     = 4'd0,
      PH_ADDR_HI  = 4'd1,
      PH_ADDR_LO  = 4'd2,
      PH_READ_HI  = 4'd3,
      PH_READ_LO  = 4'd4,
      PH_CAPD_HI  = 4'd5,
      PH_CAPD_LO  = 4'd6,
      PH_WRITE_HI = 4'd7,
      PH_WRITE_LO = 4'd8
   } phase_type;

   // Single-bit fields of one tick request.
   typedef struct packed {
      logic valid;
      logic write;
      logic ack;
   } req_flags_type;

   // Strobes and status bits of one result.
   typedef struct packed {
      logic cap_addr;
      logic cap_data;
      logic cr_read;
      logic cr_write;
      logic busy;
      logic done;
      logic timed_out;
   } rsp_ctl_type;

endpackage

// ----- hdl/phy_cr_bus_handshake_master.sv -----
// ----------------------------------------------------------------------------
// PHY control-register bus handshake master
// Drives four-phase address, read and write handshakes on a PHY CR bus.
// ----------------------------------------------------------------------------
// Every request is one clock tick of the PHY bus and yields exactly one
// response. Requests enter a two-entry queue; the sequencer takes one request
// per cycle whenever the two-entry response queue has room, so the block
// sustains one request per cycle. Each request leaves the request queue for
// the sequencer, which pushes its response into the response queue; the
// head of that queue drives the result ports. The phase and wait-count
// update made for each request taken sets that rate. The timeout register
// is written through csr_we/csr_wdata and resets to 1000000 ticks.
module phy_cr_bus_handshake_master #(
   parameter int DATA_WIDTH = 16,
   parameter int ADDR_WIDTH = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_push,
   output logic                            req_full,
   input  logic                            req_valid,
   input  logic                            req_write,
   input  logic [ADDR_WIDTH-1:0]           req_addr,
   input  logic [DATA_WIDTH-1:0]           req_wdata,
   input  logic                            req_phy_ack,
   input  logic [DATA_WIDTH-1:0]           req_phy_rdata,
   output logic                            rsp_empty,
   input  logic                            rsp_pop,
   output logic [DATA_WIDTH-1:0]           rsp_cr_data_in,
   output logic                            rsp_cap_addr,
   output logic                            rsp_cap_data,
   output logic                            rsp_cr_read,
   output logic                            rsp_cr_write,
   output logic                            rsp_busy_res,
   output logic                            rsp_done_res,
   output logic [DATA_WIDTH-1:0]           rsp_read_result,
   output logic                            rsp_timed_out,
   input  logic                            csr_we,
   input  logic [pcbhm_pkg::TIMEOUT_W-1:0] csr_wdata
);

   localparam int FLAGS_W = $bits(pcbhm_pkg::req_flags_type);
   localparam int CTL_W   = $bits(pcbhm_pkg::rsp_ctl_type);
   localparam int REQ_W   = FLAGS_W + ADDR_WIDTH + 2 * DATA_WIDTH;
   localparam int RSP_W   = CTL_W + 2 * DATA_WIDTH;

   pcbhm_pkg::req_flags_type in_flags;
   pcbhm_pkg::req_flags_type q_flags;
   logic [REQ_W-1:0]         req_word;
   logic [REQ_W-1:0]         q_word;
   logic [ADDR_WIDTH-1:0]    q_addr;
   logic [DATA_WIDTH-1:0]    q_wdata;
   logic [DATA_WIDTH-1:0]    q_rdata;
   logic                     q_empty;
   logic                     take;
   logic                     out_full;
   pcbhm_pkg::rsp_ctl_type   seq_ctl;
   pcbhm_pkg::rsp_ctl_type   out_ctl;
   logic [DATA_WIDTH-1:0]    seq_data_in;
   logic [DATA_WIDTH-1:0]    seq_read_result;
   logic [RSP_W-1:0]         rsp_word_in;
   logic [RSP_W-1:0]         rsp_word;

   assign in_flags.valid = req_valid;
   assign in_flags.write = req_write;
   assign in_flags.ack   = req_phy_ack;
   assign req_word = {in_flags, req_addr, req_wdata, req_phy_rdata};

   pcbhm_queue #(.WIDTH(REQ_W)) u_req_q (
      .clock (clock),
      .reset (reset),
      .push  (req_push),
      .wdata (req_word),
      .full  (req_full),
      .pop   (take),
      .rdata (q_word),
      .empty (q_empty)
   );

   assign {q_flags, q_addr, q_wdata, q_rdata} = q_word;

   pcbhm_seq #(
      .DATA_WIDTH (DATA_WIDTH),
      .ADDR_WIDTH (ADDR_WIDTH)
   ) u_seq (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata),
      .item_avail      (!q_empty),
      .item_flags      (q_flags),
      .item_addr       (q_addr),
      .item_wdata      (q_wdata),
      .item_rdata      (q_rdata),
      .out_full        (out_full),
      .item_take       (take),
      .rsp_ctl         (seq_ctl),
      .rsp_data_in     (seq_data_in),
      .rsp_read_result (seq_read_result)
   );

   assign rsp_word_in = {seq_ctl, seq_data_in, seq_read_result};

   pcbhm_queue #(.WIDTH(RSP_W)) u_rsp_q (
      .clock (clock),
      .reset (reset),
      .push  (take),
      .wdata (rsp_word_in),
      .full  (out_full),
      .pop   (rsp_pop),
      .rdata (rsp_word),
      .empty (rsp_empty)
   );

   assign {out_ctl, rsp_cr_data_in, rsp_read_result} = rsp_word;
   assign rsp_cap_addr  = out_ctl.cap_addr;
   assign rsp_cap_data  = out_ctl.cap_data;
   assign rsp_cr_read   = out_ctl.cr_read;
   assign rsp_cr_write  = out_ctl.cr_write;
   assign rsp_busy_res  = out_ctl.busy;
   assign rsp_done_res  = out_ctl.done;
   assign rsp_timed_out = out_ctl.timed_out;

endmodule

// ----- hdl/pcbhm_queue.sv -----
// ----------------------------------------------------------------------------
// Two-entry queue
// Small register queue that decouples a producer and a consumer.
// ----------------------------------------------------------------------------
module pcbhm_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   localparam int DEPTH = 2;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

// ----- hdl/pcbhm_seq.sv -----
// ----------------------------------------------------------------------------
// Handshake sequencer
// Steps the four-phase handshake by one tick for every request taken.
// ----------------------------------------------------------------------------
module pcbhm_seq #(
   parameter int DATA_WIDTH = 16,
   parameter int ADDR_WIDTH = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [pcbhm_pkg::TIMEOUT_W-1:0] csr_wdata,
   input  logic                           item_avail,
   input  pcbhm_pkg::req_flags_type       item_flags,
   input  logic [ADDR_WIDTH-1:0]          item_addr,
   input  logic [DATA_WIDTH-1:0]          item_wdata,
   input  logic [DATA_WIDTH-1:0]          item_rdata,
   input  logic                           out_full,
   output logic                           item_take,
   output pcbhm_pkg::rsp_ctl_type         rsp_ctl,
   output logic [DATA_WIDTH-1:0]          rsp_data_in,
   output logic [DATA_WIDTH-1:0]          rsp_read_result
);

   localparam int TW = pcbhm_pkg::TIMEOUT_W;

   pcbhm_pkg::phase_type   phase_ff, phase_in;
   logic [TW-1:0]          timeout_ff;
   logic [TW-1:0]          wait_ff, wait_in;
   logic [ADDR_WIDTH-1:0]  addr_ff, addr_in;
   logic [DATA_WIDTH-1:0]  wdata_ff, wdata_in;
   logic                   is_write_ff, is_write_in;
   logic [DATA_WIDTH-1:0]  rdata_ff, rdata_in;
   logic                   tseen_ff, tseen_in;
   logic [TW-1:0]          wait_inc;
   logic                   hit;
   logic                   advance;
   logic                   done;

   function automatic logic wants_high(pcbhm_pkg::phase_type p);
      logic r;
      case (p) inside
         pcbhm_pkg::PH_ADDR_HI, pcbhm_pkg::PH_READ_HI,
         pcbhm_pkg::PH_CAPD_HI, pcbhm_pkg::PH_WRITE_HI: r = 1'b1;
         default: r = 1'b0;
      endcase
      return r;
   endfunction

   assign item_take = item_avail && !out_full;
   assign wait_inc  = wait_ff + TW'(1);

   always_comb begin
      phase_in    = phase_ff;
      wait_in     = wait_ff;
      addr_in     = addr_ff;
      wdata_in    = wdata_ff;
      is_write_in = is_write_ff;
      rdata_in    = rdata_ff;
      tseen_in    = tseen_ff;
      hit         = 1'b0;
      advance     = 1'b0;
      done        = 1'b0;
      if (item_take) begin
         case (phase_ff)
            pcbhm_pkg::PH_IDLE: begin
               if (item_flags.valid) begin
                  addr_in     = item_addr;
                  wdata_in    = item_wdata;
                  is_write_in = item_flags.write;
                  tseen_in    = 1'b0;
                  wait_in     = '0;
                  phase_in    = pcbhm_pkg::PH_ADDR_HI;
               end
            end
            pcbhm_pkg::PH_ADDR_HI, pcbhm_pkg::PH_ADDR_LO,
            pcbhm_pkg::PH_READ_HI, pcbhm_pkg::PH_READ_LO,
            pcbhm_pkg::PH_CAPD_HI, pcbhm_pkg::PH_CAPD_LO,
            pcbhm_pkg::PH_WRITE_HI, pcbhm_pkg::PH_WRITE_LO: begin
               hit     = wants_high(phase_ff) ? item_flags.ack : !item_flags.ack;
               advance = hit;
               if (!hit) begin
                  wait_in = wait_inc;
                  if (wait_inc >= timeout_ff) begin
                     tseen_in = 1'b1;
                     advance  = 1'b1;
                  end
               end
               if (advance) begin
                  // A read-high wait that times out still latches the data lines.
                  if (phase_ff == pcbhm_pkg::PH_READ_HI) begin
                     rdata_in = item_rdata;
                  end
                  wait_in = '0;
                  case (phase_ff)
                     pcbhm_pkg::PH_ADDR_HI:  phase_in = pcbhm_pkg::PH_ADDR_LO;
                     pcbhm_pkg::PH_ADDR_LO:  phase_in = is_write_ff ? pcbhm_pkg::PH_CAPD_HI
                                                                    : pcbhm_pkg::PH_READ_HI;
                     pcbhm_pkg::PH_READ_HI:  phase_in = pcbhm_pkg::PH_READ_LO;
                     pcbhm_pkg::PH_CAPD_HI:  phase_in = pcbhm_pkg::PH_CAPD_LO;
                     pcbhm_pkg::PH_CAPD_LO:  phase_in = pcbhm_pkg::PH_WRITE_HI;
                     pcbhm_pkg::PH_WRITE_HI: phase_in = pcbhm_pkg::PH_WRITE_LO;
                     default:                phase_in = pcbhm_pkg::PH_IDLE;
                  endcase
                  done = (phase_in == pcbhm_pkg::PH_IDLE);
               end
            end
            default: begin
               phase_in = pcbhm_pkg::PH_IDLE;
               wait_in  = '0;
            end
         endcase
      end

      rsp_ctl.cap_addr  = (phase_in == pcbhm_pkg::PH_ADDR_HI);
      rsp_ctl.cap_data  = (phase_in == pcbhm_pkg::PH_CAPD_HI);
      rsp_ctl.cr_read   = (phase_in == pcbhm_pkg::PH_READ_HI);
      rsp_ctl.cr_write  = (phase_in == pcbhm_pkg::PH_WRITE_HI);
      rsp_ctl.busy      = (phase_in != pcbhm_pkg::PH_IDLE);
      rsp_ctl.done      = done;
      rsp_ctl.timed_out = done && tseen_in;
      rsp_read_result   = rdata_in;
      case (phase_in) inside
         pcbhm_pkg::PH_ADDR_HI, pcbhm_pkg::PH_ADDR_LO:
            rsp_data_in = DATA_WIDTH'(addr_in);
         [pcbhm_pkg::PH_CAPD_HI:pcbhm_pkg::PH_WRITE_LO]:
            rsp_data_in = wdata_in;
         default:
            rsp_data_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= pcbhm_pkg::PH_IDLE;
         wait_ff     <= '0;
         addr_ff     <= '0;
         wdata_ff    <= '0;
         is_write_ff <= 1'b0;
         rdata_ff    <= '0;
         tseen_ff    <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         wait_ff     <= wait_in;
         addr_ff     <= addr_in;
         wdata_ff    <= wdata_in;
         is_write_ff <= is_write_in;
         rdata_ff    <= rdata_in;
         tseen_ff    <= tseen_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= pcbhm_pkg::TIMEOUT_RESET;
      end else if (csr_we) begin
         timeout_ff <= csr_wdata;
      end
   end

endmodule

// ----- tb/phy_cr_bus_handshake_master_tb.sv -----
// ----------------------------------------------------------------------------
// PHY control-register bus handshake master testbench
// Sends bus ticks (requests plus PHY ack and data-out levels) into the block,
// predicts the strobes, data-in lines and status of every tick, and compares
// each response field by field. Directed read, write and timeout sequences
// come first, then a long stall of the response side, then random
// transactions under changing timeout settings and idle patterns.
// ----------------------------------------------------------------------------
module phy_cr_bus_handshake_master_tb;

   localparam int DATA_W = 16;
   localparam int ADDR_W = 16;
   localparam int TW = pcbhm_pkg::TIMEOUT_W;
   localparam int TICK_LIMIT = 500000;
   localparam int SETTLE_CYCLES = 8;
   localparam int RANDOM_TICKS = 1560;
   localparam int ERROR_PRINTS = 20;

   typedef struct packed {
      logic              valid;
      logic              write;
      logic [ADDR_W-1:0] addr;
      logic [DATA_W-1:0] wdata;
      logic              ack;
      logic [DATA_W-1:0] rdata;
   } bus_tick_type;

   typedef struct packed {
      logic [DATA_W-1:0]      data_in;
      pcbhm_pkg::rsp_ctl_type ctl;
      logic [DATA_W-1:0]      read_result;
   } bus_result_type;

   localparam int TICK_W = $bits(bus_tick_type);

   // How the emulated PHY answers the strobes.
   typedef enum int unsigned {
      PHY_PROMPT,
      PHY_SLOW,
      PHY_STUCK_LOW,
      PHY_STUCK_HIGH
   } phy_mode_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_push = 1'b0;
   logic                 req_full;
   logic                 req_valid = 1'b0;
   logic                 req_write = 1'b0;
   logic [ADDR_W-1:0]    req_addr = '0;
   logic [DATA_W-1:0]    req_wdata = '0;
   logic                 req_phy_ack = 1'b0;
   logic [DATA_W-1:0]    req_phy_rdata = '0;
   logic                 rsp_empty;
   logic                 rsp_pop = 1'b0;
   logic [DATA_W-1:0]    rsp_cr_data_in;
   logic                 rsp_cap_addr;
   logic                 rsp_cap_data;
   logic                 rsp_cr_read;
   logic                 rsp_cr_write;
   logic                 rsp_busy_res;
   logic                 rsp_done_res;
   logic [DATA_W-1:0]    rsp_read_result;
   logic                 rsp_timed_out;
   logic                 csr_we = 1'b0;
   logic [TW-1:0]        csr_wdata = '0;

   // Predicted bus master state.
   pcbhm_pkg::phase_type bus_phase = pcbhm_pkg::PH_IDLE;
   logic [TW-1:0]        wait_ticks = '0;
   logic [TW-1:0]        timeout_ticks = pcbhm_pkg::TIMEOUT_RESET;
   logic [ADDR_W-1:0]    held_addr = '0;
   logic [DATA_W-1:0]    held_wdata = '0;
   logic                 held_write = 1'b0;
   logic [DATA_W-1:0]    last_rdata = '0;
   logic                 timeout_flag = 1'b0;

   bus_result_type bus_outputs_due[$];
   int unsigned  send_gap_max = 0;
   int unsigned  rsp_gap_max = 0;
   int unsigned  rsp_hold = 0;
   int unsigned  tick_count = 0;
   int unsigned  full_stalls = 0;
   int unsigned  done_count = 0;
   int unsigned  timeout_done_count = 0;
   int unsigned  error_count = 0;
   int unsigned  cycle_count = 0;

   phy_cr_bus_handshake_master #(
      .DATA_WIDTH(DATA_W),
      .ADDR_WIDTH(ADDR_W)
   ) DUT (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_valid      (req_valid),
      .req_write      (req_write),
      .req_addr       (req_addr),
      .req_wdata      (req_wdata),
      .req_phy_ack    (req_phy_ack),
      .req_phy_rdata  (req_phy_rdata),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_cr_data_in (rsp_cr_data_in),
      .rsp_cap_addr   (rsp_cap_addr),
      .rsp_cap_data   (rsp_cap_data),
      .rsp_cr_read    (rsp_cr_read),
      .rsp_cr_write   (rsp_cr_write),
      .rsp_busy_res   (rsp_busy_res),
      .rsp_done_res   (rsp_done_res),
      .rsp_read_result(rsp_read_result),
      .rsp_timed_out  (rsp_timed_out),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count = cycle_count + 1;
      if (cycle_count >= TICK_LIMIT) begin
         $display("%0t: no progress, run stopped after %0d cycles", $time, cycle_count);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Strobe phases wait for ack high, release phases for ack low.
   function automatic logic strobe_phase(input pcbhm_pkg::phase_type p);
      return p == pcbhm_pkg::PH_ADDR_HI || p == pcbhm_pkg::PH_READ_HI ||
             p == pcbhm_pkg::PH_CAPD_HI || p == pcbhm_pkg::PH_WRITE_HI;
   endfunction

   function automatic int unsigned draw_gap_max();
      case ($urandom_range(0, 2))
         0: return 0;
         1: return 3;
         default: return 18;
      endcase
   endfunction

   // Advances the predicted master by one bus tick and returns its outputs.
   function automatic bus_result_type advance_bus(input bus_tick_type t);
      bus_result_type r;
      logic        hit;
      logic        moving;
      logic        finished;
      finished = 1'b0;
      if (bus_phase == pcbhm_pkg::PH_IDLE) begin
         if (t.valid) begin
            held_addr = t.addr;
            held_wdata = t.wdata;
            held_write = t.write;
            timeout_flag = 1'b0;
            wait_ticks = '0;
            bus_phase = pcbhm_pkg::PH_ADDR_HI;
         end
      end else begin
         hit = strobe_phase(bus_phase) ? t.ack : !t.ack;
         moving = hit;
         if (!hit) begin
            wait_ticks = wait_ticks + TW'(1);
            if (wait_ticks >= timeout_ticks) begin
               timeout_flag = 1'b1;
               moving = 1'b1;
            end
         end
         if (moving) begin
            // A read that times out still latches whatever the PHY drives.
            if (bus_phase == pcbhm_pkg::PH_READ_HI) begin
               last_rdata = t.rdata;
            end
            wait_ticks = '0;
            case (bus_phase)
               pcbhm_pkg::PH_ADDR_HI:  bus_phase = pcbhm_pkg::PH_ADDR_LO;
               pcbhm_pkg::PH_ADDR_LO:  bus_phase = held_write ? pcbhm_pkg::PH_CAPD_HI
                                                              : pcbhm_pkg::PH_READ_HI;
               pcbhm_pkg::PH_READ_HI:  bus_phase = pcbhm_pkg::PH_READ_LO;
               pcbhm_pkg::PH_CAPD_HI:  bus_phase = pcbhm_pkg::PH_CAPD_LO;
               pcbhm_pkg::PH_CAPD_LO:  bus_phase = pcbhm_pkg::PH_WRITE_HI;
               pcbhm_pkg::PH_WRITE_HI: bus_phase = pcbhm_pkg::PH_WRITE_LO;
               default:                bus_phase = pcbhm_pkg::PH_IDLE;
            endcase
            finished = (bus_phase == pcbhm_pkg::PH_IDLE);
         end
      end
      r = '0;
      case (bus_phase)
         pcbhm_pkg::PH_ADDR_HI, pcbhm_pkg::PH_ADDR_LO: r.data_in = held_addr;
         pcbhm_pkg::PH_CAPD_HI, pcbhm_pkg::PH_CAPD_LO,
         pcbhm_pkg::PH_WRITE_HI, pcbhm_pkg::PH_WRITE_LO: r.data_in = held_wdata;
         default: r.data_in = '0;
      endcase
      r.ctl.cap_addr = (bus_phase == pcbhm_pkg::PH_ADDR_HI);
      r.ctl.cap_data = (bus_phase == pcbhm_pkg::PH_CAPD_HI);
      r.ctl.cr_read = (bus_phase == pcbhm_pkg::PH_READ_HI);
      r.ctl.cr_write = (bus_phase == pcbhm_pkg::PH_WRITE_HI);
      r.ctl.busy = (bus_phase != pcbhm_pkg::PH_IDLE);
      r.ctl.done = finished;
      r.ctl.timed_out = finished & timeout_flag;
      r.read_result = last_rdata;
      return r;
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         error_count++;
         if (error_count <= ERROR_PRINTS) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         end
      end
   endfunction

   // Sends one bus tick; returns at the edge that accepted it.
   task automatic send_tick(input bus_tick_type t);
      int unsigned gap;
      gap = $urandom_range(0, send_gap_max);
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1'b1;
      req_valid <= t.valid;
      req_write <= t.write;
      req_addr <= t.addr;
      req_wdata <= t.wdata;
      req_phy_ack <= t.ack;
      req_phy_rdata <= t.rdata;
      @(negedge clock);
      while (req_full) begin
         full_stalls++;
         @(negedge clock);
      end
      @(posedge clock);
      bus_outputs_due.push_back(advance_bus(t));
      tick_count++;
   endtask

   // Writes the timeout register once every response is back.
   task automatic set_timeout(input logic [TW-1:0] ticks);
      req_push <= 1'b0;
      while (bus_outputs_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= ticks;
      @(posedge clock);
      csr_we <= 1'b0;
      timeout_ticks = ticks;
   endtask

   // Plays the PHY side until the current transaction completes. Busy ticks
   // carry a new request with the given percentage, which must be ignored.
   task automatic finish_transaction(input phy_mode_type mode,
                                     input logic [DATA_W-1:0] rdata,
                                     input int unsigned busy_req_pct);
      bus_tick_type t;
      logic      wanted;
      while (bus_phase != pcbhm_pkg::PH_IDLE) begin
         wanted = strobe_phase(bus_phase);
         t.valid = ($urandom_range(0, 99) < busy_req_pct);
         t.write = 1'($urandom_range(0, 1));
         t.addr = ADDR_W'($urandom);
         t.wdata = DATA_W'($urandom);
         t.rdata = rdata;
         case (mode)
            PHY_PROMPT:    t.ack = wanted;
            PHY_SLOW:      t.ack = ($urandom_range(0, 99) < 55) ? wanted : !wanted;
            PHY_STUCK_LOW: t.ack = 1'b0;
            default:       t.ack = 1'b1;
         endcase
         send_tick(t);
      end
   endtask

   task automatic run_transaction(input logic write, input logic [ADDR_W-1:0] addr,
                                  input logic [DATA_W-1:0] wdata,
                                  input logic [DATA_W-1:0] rdata, input phy_mode_type mode,
                                  input int unsigned busy_req_pct);
      bus_tick_type t;
      t.valid = 1'b1;
      t.write = write;
      t.addr = addr;
      t.wdata = wdata;
      // Ack on the request tick itself is not looked at.
      t.ack = 1'($urandom_range(0, 1));
      t.rdata = DATA_W'($urandom);
      send_tick(t);
      finish_transaction(mode, rdata, busy_req_pct);
   endtask

   task automatic idle_tick();
      bus_tick_type t;
      t = '0;
      t.write = 1'($urandom_range(0, 1));
      t.addr = ADDR_W'($urandom);
      t.wdata = DATA_W'($urandom);
      t.ack = 1'($urandom_range(0, 1));
      t.rdata = DATA_W'($urandom);
      send_tick(t);
   endtask

   task automatic test_read_path();
      send_gap_max = 18;
      rsp_gap_max = 0;
      idle_tick();
      run_transaction(1'b0, 16'hFFFF, 16'h0000, 16'hFFFF, PHY_PROMPT, 100);
      idle_tick();
      run_transaction(1'b0, 16'h0000, 16'hFFFF, 16'h0000, PHY_PROMPT, 0);
   endtask

   task automatic test_write_path();
      send_gap_max = 0;
      rsp_gap_max = 18;
      run_transaction(1'b1, 16'h0000, 16'hFFFF, 16'h5A5A, PHY_PROMPT, 100);
      run_transaction(1'b1, 16'hFFFF, 16'h0000, 16'hA5A5, PHY_PROMPT, 0);
   endtask

   task automatic test_timeouts();
      send_gap_max = 3;
      rsp_gap_max = 3;
      set_timeout(32'd1);
      run_transaction(1'b0, 16'h1234, 16'h0000, 16'hBEEF, PHY_STUCK_LOW, 100);
      // A zero setting must act like a one-tick timeout.
      set_timeout(32'd0);
      run_transaction(1'b1, 16'h4321, 16'hC0DE, 16'h0000, PHY_STUCK_HIGH, 100);
   endtask

   task automatic test_backpressure();
      set_timeout(32'hFFFF_FFFF);
      send_gap_max = 0;
      rsp_hold = 200;
      repeat (8) begin
         run_transaction(1'($urandom_range(0, 1)), ADDR_W'($urandom), DATA_W'($urandom),
                         DATA_W'($urandom), PHY_PROMPT, 30);
      end
   endtask

   task automatic test_random();
      int unsigned  stop_at;
      int unsigned  pick;
      phy_mode_type mode;
      stop_at = tick_count + RANDOM_TICKS;
      while (tick_count < stop_at) begin
         if ($urandom_range(0, 11) == 0) begin
            case ($urandom_range(0, 6))
               0: set_timeout(32'd0);
               1: set_timeout(32'd1);
               2: set_timeout($urandom_range(2, 8));
               3: set_timeout(pcbhm_pkg::TIMEOUT_RESET);
               4: set_timeout(32'hFFFF_FFFF);
               default: set_timeout($urandom);
            endcase
            send_gap_max = draw_gap_max();
            rsp_gap_max = draw_gap_max();
         end
         // A PHY that never answers is only safe with a short timeout.
         if (timeout_ticks <= 8) begin
            mode = phy_mode_type'($urandom_range(0, 3));
         end else begin
            mode = phy_mode_type'($urandom_range(0, 1));
         end
         pick = $urandom_range(0, 9);
         if (pick < 7) begin
            run_transaction(1'($urandom_range(0, 1)), ADDR_W'($urandom), DATA_W'($urandom),
                            DATA_W'($urandom), mode, 30);
         end else if (pick < 8) begin
            repeat ($urandom_range(1, 3)) idle_tick();
         end else begin
            repeat ($urandom_range(1, 6)) begin
               send_tick(bus_tick_type'(TICK_W'({$urandom, $urandom})));
            end
            finish_transaction(mode, DATA_W'($urandom), 30);
         end
      end
   endtask

   // Response side: pops after a drawn pause and checks against the oldest
   // predicted tick.
   initial begin
      int unsigned    gap;
      bus_result_type got;
      bus_result_type want;
      wait (!reset);
      @(posedge clock);
      forever begin
         if (rsp_hold > 0) begin
            gap = rsp_hold;
            rsp_hold = 0;
         end else begin
            gap = $urandom_range(0, rsp_gap_max);
         end
         if (gap > 0) begin
            rsp_pop <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         @(negedge clock);
         while (rsp_empty) @(negedge clock);
         got.data_in = rsp_cr_data_in;
         got.ctl.cap_addr = rsp_cap_addr;
         got.ctl.cap_data = rsp_cap_data;
         got.ctl.cr_read = rsp_cr_read;
         got.ctl.cr_write = rsp_cr_write;
         got.ctl.busy = rsp_busy_res;
         got.ctl.done = rsp_done_res;
         got.ctl.timed_out = rsp_timed_out;
         got.read_result = rsp_read_result;
         @(posedge clock);
         if (bus_outputs_due.size() == 0) begin
            error_count++;
            $display("%0t: response with no request outstanding, expected none, actual %h",
                     $time, got);
         end else begin
            want = bus_outputs_due.pop_front();
            check_field("cr_data_in", 32'(want.data_in), 32'(got.data_in));
            check_field("cap_addr", 32'(want.ctl.cap_addr), 32'(got.ctl.cap_addr));
            check_field("cap_data", 32'(want.ctl.cap_data), 32'(got.ctl.cap_data));
            check_field("cr_read", 32'(want.ctl.cr_read), 32'(got.ctl.cr_read));
            check_field("cr_write", 32'(want.ctl.cr_write), 32'(got.ctl.cr_write));
            check_field("busy_res", 32'(want.ctl.busy), 32'(got.ctl.busy));
            check_field("done_res", 32'(want.ctl.done), 32'(got.ctl.done));
            check_field("read_result", 32'(want.read_result), 32'(got.read_result));
            check_field("timed_out", 32'(want.ctl.timed_out), 32'(got.ctl.timed_out));
            if (want.ctl.done) begin
               done_count++;
            end
            if (want.ctl.timed_out) begin
               timeout_done_count++;
            end
         end
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_read_path();
      test_write_path();
      test_timeouts();
      test_backpressure();
      test_random();
      req_push <= 1'b0;
      while (bus_outputs_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Sent %0d requests; %0d transactions completed, %0d of them timed out.",
               tick_count, done_count, timeout_done_count);
      $display("Input side stalled for %0d cycles; %0d mismatches.", full_stalls, error_count);
      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
